// ===== design/rsum_pkg.sv =====
// ----------------------------------------------------------------------------
// rsum_pkg
// Shared types and constants of the range sum tree: request and result
// records, field widths and code values.
// ----------------------------------------------------------------------------
package rsum_pkg;

    localparam int SUM_W     = 64;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 1024;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
        logic [POS_W-1:0]        range_low;
        logic [POS_W-1:0]        range_high;
    } t_req;

    typedef struct packed {
        logic [SUM_W-1:0] range_sum;
        logic             status;
    } t_result;

endpackage

// ===== design/rsum_mem.sv =====
// ----------------------------------------------------------------------------
// rsum_mem
// Node sum store: one write port and one read port with registered read
// data. Addresses at or beyond the depth read as zero and are not written.
// ----------------------------------------------------------------------------
module rsum_mem #(
    parameter int AW         = 11,
    parameter int TREE_NODES = 2048
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [rsum_pkg::SUM_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [rsum_pkg::SUM_W-1:0] i_wr_data
);

    localparam int ADDR_W = $clog2(TREE_NODES);

    logic [rsum_pkg::SUM_W-1:0] r_mem [TREE_NODES];
    logic [rsum_pkg::SUM_W-1:0] r_rd_data;
    logic                       w_rd_ok;
    logic                       w_wr_ok;

    // compare one bit wider so a depth of exactly 2**AW still fits
    assign w_rd_ok = {1'b0, i_rd_addr} < (AW+1)'(TREE_NODES);
    assign w_wr_ok = {1'b0, i_wr_addr} < (AW+1)'(TREE_NODES);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_ok) begin
            r_mem[i_wr_addr[ADDR_W-1:0]] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= w_rd_ok ? r_mem[i_rd_addr[ADDR_W-1:0]] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/rsum_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsum_ctrl
// Tree walker. An update descends to its leaf, then climbs to the root
// reading one sibling and writing one parent sum per cycle. A query descends
// to the split node, then follows the left and right boundary paths, reading
// each fully covered node into an accumulator.
// ----------------------------------------------------------------------------
module rsum_ctrl #(
    parameter int MAX_LEAVES = 1024,
    parameter int NODE_W     = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  rsum_pkg::t_req                      i_req,
    input  logic [$clog2(MAX_LEAVES+1)-1:0]     i_eff_len,
    output logic                                o_idle,
    output logic                                o_done,
    input  logic                                i_take,
    output rsum_pkg::t_result                   o_result,
    output logic                                o_rd_en,
    output logic [NODE_W-1:0]                   o_rd_addr,
    input  logic [rsum_pkg::SUM_W-1:0]          i_rd_data,
    output logic                                o_wr_en,
    output logic [NODE_W-1:0]                   o_wr_addr,
    output logic [rsum_pkg::SUM_W-1:0]          o_wr_data
);

    localparam int IDX_W = $clog2(MAX_LEAVES);
    localparam int LEN_W = $clog2(MAX_LEAVES + 1);
    localparam int CW    = (LEN_W > rsum_pkg::POS_W) ? LEN_W : rsum_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD_DOWN,
        S_UPD_RISE,
        S_QRY_SPLIT,
        S_QRY_LEFT,
        S_QRY_RIGHT,
        S_QRY_DRAIN,
        S_DONE
    } t_state;

    t_state                     r_state,  n_state;
    logic [NODE_W-1:0]          r_node,   n_node;
    logic [IDX_W-1:0]           r_lo,     n_lo;
    logic [IDX_W-1:0]           r_hi,     n_hi;
    logic [IDX_W-1:0]           r_a,      n_a;
    logic [IDX_W-1:0]           r_b,      n_b;
    logic [NODE_W-1:0]          r_rnode,  n_rnode;
    logic [IDX_W-1:0]           r_rlo,    n_rlo;
    logic [IDX_W-1:0]           r_rhi,    n_rhi;
    logic [rsum_pkg::SUM_W-1:0] r_val,    n_val;
    logic [rsum_pkg::SUM_W-1:0] r_acc,    n_acc;
    logic                       r_rd_pend, n_rd_pend;
    logic [rsum_pkg::SUM_W-1:0] r_sum,    n_sum;
    logic                       r_status, n_status;

    logic [IDX_W:0]             w_mid_sum;
    logic [IDX_W-1:0]           w_mid;
    logic [IDX_W-1:0]           w_mid_p1;
    logic [NODE_W-1:0]          w_left;
    logic [NODE_W-1:0]          w_right;
    logic [NODE_W-1:0]          w_sib;
    logic [NODE_W-1:0]          w_nm1;
    logic [NODE_W-1:0]          w_parent;
    logic [CW-1:0]              w_len_c;
    logic [CW-1:0]              w_last_c;
    logic [CW-1:0]              w_pos_c;
    logic [CW-1:0]              w_a_c;
    logic [CW-1:0]              w_b_c;
    logic [CW-1:0]              w_b_clip;
    logic [rsum_pkg::SUM_W-1:0] w_acc;
    logic [rsum_pkg::SUM_W-1:0] w_up_sum;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[IDX_W:1];
    assign w_mid_p1  = w_mid + IDX_W'(1);
    assign w_left    = {r_node[NODE_W-2:0], 1'b1};
    assign w_right   = {r_node[NODE_W-2:0], 1'b0} + NODE_W'(2);
    assign w_sib     = r_node[0] ? r_node + NODE_W'(1) : r_node - NODE_W'(1);
    assign w_nm1     = r_node - NODE_W'(1);
    assign w_parent  = {1'b0, w_nm1[NODE_W-1:1]};

    assign w_len_c   = CW'(i_eff_len);
    assign w_last_c  = w_len_c - CW'(1);
    assign w_pos_c   = CW'(i_req.position);
    assign w_a_c     = CW'(i_req.range_low);
    assign w_b_c     = CW'(i_req.range_high);
    assign w_b_clip  = (w_b_c > w_last_c) ? w_last_c : w_b_c;

    assign w_acc     = r_acc + (r_rd_pend ? i_rd_data : '0);
    assign w_up_sum  = r_val + i_rd_data;

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_a       = r_a;
        n_b       = r_b;
        n_rnode   = r_rnode;
        n_rlo     = r_rlo;
        n_rhi     = r_rhi;
        n_val     = r_val;
        n_acc     = w_acc;
        n_sum     = r_sum;
        n_status  = r_status;
        o_rd_en   = 1'b0;
        o_rd_addr = r_node;
        o_wr_en   = 1'b0;
        o_wr_addr = r_node;
        o_wr_data = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_node   = '0;
                    n_lo     = '0;
                    n_hi     = w_last_c[IDX_W-1:0];
                    n_acc    = '0;
                    n_sum    = '0;
                    n_status = rsum_pkg::STATUS_OK;
                    if (i_req.req_type == rsum_pkg::REQ_UPDATE) begin
                        n_a   = w_pos_c[IDX_W-1:0];
                        n_val = {{(rsum_pkg::SUM_W - rsum_pkg::VAL_W){i_req.new_value[rsum_pkg::VAL_W-1]}},
                                 i_req.new_value};
                        if (w_pos_c < w_len_c) begin
                            n_state = S_UPD_DOWN;
                        end else begin
                            n_status = rsum_pkg::STATUS_DROPPED;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_a = w_a_c[IDX_W-1:0];
                        n_b = w_b_clip[IDX_W-1:0];
                        if (w_a_c <= w_b_clip) begin
                            n_state = S_QRY_SPLIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            S_UPD_DOWN: begin
                if (r_lo == r_hi) begin
                    // leaf reached: store the value, fetch the sibling unless the leaf is the root
                    o_wr_en = 1'b1;
                    if (r_node == '0) begin
                        n_state = S_DONE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_sib;
                        n_state   = S_UPD_RISE;
                    end
                end else if (r_a <= w_mid) begin
                    n_node = w_left;
                    n_hi   = w_mid;
                end else begin
                    n_node = w_right;
                    n_lo   = w_mid_p1;
                end
            end

            S_UPD_RISE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = w_parent;
                o_wr_data = w_up_sum;
                n_val     = w_up_sum;
                n_node    = w_parent;
                if (w_parent == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_parent[0] ? w_parent + NODE_W'(1) : w_parent - NODE_W'(1);
                end
            end

            S_QRY_SPLIT: begin
                if (r_a <= r_lo && r_b >= r_hi) begin
                    o_rd_en = 1'b1;
                    n_state = S_QRY_DRAIN;
                end else if (r_b <= w_mid) begin
                    n_node = w_left;
                    n_hi   = w_mid;
                end else if (r_a > w_mid) begin
                    n_node = w_right;
                    n_lo   = w_mid_p1;
                end else begin
                    n_rnode = w_right;
                    n_rlo   = w_mid_p1;
                    n_rhi   = r_hi;
                    n_node  = w_left;
                    n_hi    = w_mid;
                    n_state = S_QRY_LEFT;
                end
            end

            S_QRY_LEFT: begin
                if (r_a <= r_lo) begin
                    o_rd_en = 1'b1;
                    n_node  = r_rnode;
                    n_lo    = r_rlo;
                    n_hi    = r_rhi;
                    n_state = S_QRY_RIGHT;
                end else if (r_a <= w_mid) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_right;
                    n_node    = w_left;
                    n_hi      = w_mid;
                end else begin
                    n_node = w_right;
                    n_lo   = w_mid_p1;
                end
            end

            S_QRY_RIGHT: begin
                if (r_b >= r_hi) begin
                    o_rd_en = 1'b1;
                    n_state = S_QRY_DRAIN;
                end else if (r_b > w_mid) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_left;
                    n_node    = w_right;
                    n_lo      = w_mid_p1;
                end else begin
                    n_node = w_left;
                    n_hi   = w_mid;
                end
            end

            S_QRY_DRAIN: begin
                n_sum   = w_acc;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rd_pend = o_rd_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
        r_node   <= n_node;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_a      <= n_a;
        r_b      <= n_b;
        r_rnode  <= n_rnode;
        r_rlo    <= n_rlo;
        r_rhi    <= n_rhi;
        r_val    <= n_val;
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_status <= n_status;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = '{range_sum: r_sum, status: r_status};

endmodule

// ===== design/range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// range_sum_tree
// Segment tree of 64-bit wrapping sums with point update and range query.
//
//   channel  direction  handshake             payload
//   in       to block   i_in_valid/o_in_stall  req_type position new_value
//                                              range_low range_high
//   out      from block o_out_valid/i_out_stall range_sum status
//   cfg      to block   i_cfg_valid/o_cfg_ready used_length
//
// A walk runs from its transfer to the result register, and the next transfer
// is taken only once it has returned to idle. The walk visits one tree level
// per cycle through the single read port. After reset and after every length
// write the node store is swept to zero with o_in_stall high; length writes
// are taken meanwhile and restart the sweep. The next item is taken while a
// result waits in the output register.
// ----------------------------------------------------------------------------
module range_sum_tree #(
    parameter int MAX_LEAVES = 1024,
    parameter int TREE_NODES = 2048
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_req_type,
    input  logic [rsum_pkg::POS_W-1:0]              i_position,
    input  logic signed [rsum_pkg::VAL_W-1:0]       i_new_value,
    input  logic [rsum_pkg::POS_W-1:0]              i_range_low,
    input  logic [rsum_pkg::POS_W-1:0]              i_range_high,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [rsum_pkg::SUM_W-1:0]       o_range_sum,
    output logic                                    o_status,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [rsum_pkg::CFG_W-1:0]              i_used_length
);

    localparam int IDX_W     = $clog2(MAX_LEAVES);
    localparam int LEN_W     = $clog2(MAX_LEAVES + 1);
    localparam int NODE_W    = IDX_W + 1;
    localparam int ADDR_W    = $clog2(TREE_NODES);
    localparam int AW        = (NODE_W > ADDR_W) ? NODE_W : ADDR_W;
    localparam int CLW       = (rsum_pkg::CFG_W > LEN_W) ? rsum_pkg::CFG_W : LEN_W;
    localparam int RESET_LEN = (rsum_pkg::CFG_RESET > MAX_LEAVES) ? MAX_LEAVES
                                                                   : rsum_pkg::CFG_RESET;

    logic [LEN_W-1:0]           r_eff_len;
    logic                       r_clr_busy;
    logic [AW-1:0]              r_clr_idx;
    logic                       r_out_valid;
    rsum_pkg::t_result          r_out;

    logic [CLW-1:0]             w_cfg_c;
    logic [CLW-1:0]             w_cfg_clamp;
    logic                       w_cfg_wr;
    logic                       w_in_xfer;
    logic                       w_take;
    rsum_pkg::t_req             w_req;

    logic                       w_ctrl_idle;
    logic                       w_ctrl_done;
    rsum_pkg::t_result          w_ctrl_result;
    logic                       w_ctrl_rd_en;
    logic [NODE_W-1:0]          w_ctrl_rd_addr;
    logic                       w_ctrl_wr_en;
    logic [NODE_W-1:0]          w_ctrl_wr_addr;
    logic [rsum_pkg::SUM_W-1:0] w_ctrl_wr_data;
    logic [rsum_pkg::SUM_W-1:0] w_rd_data;

    logic                       w_mem_wr_en;
    logic [AW-1:0]              w_mem_wr_addr;
    logic [rsum_pkg::SUM_W-1:0] w_mem_wr_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_clr_busy || !w_ctrl_idle;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_take      = !r_out_valid || !i_out_stall;

    // zero acts as one, anything above MAX_LEAVES as MAX_LEAVES
    assign w_cfg_c     = CLW'(i_used_length);
    assign w_cfg_clamp = (w_cfg_c == '0) ? CLW'(1) :
                         (w_cfg_c > CLW'(MAX_LEAVES)) ? CLW'(MAX_LEAVES) : w_cfg_c;

    assign w_req = '{req_type:   i_req_type,
                     position:   i_position,
                     new_value:  i_new_value,
                     range_low:  i_range_low,
                     range_high: i_range_high};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_len   <= LEN_W'(RESET_LEN);
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_eff_len  <= w_cfg_clamp[LEN_W-1:0];
                r_clr_busy <= 1'b1;
                r_clr_idx  <= '0;
            end else if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(TREE_NODES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_ctrl_done && w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_ctrl_done && w_take) begin
            r_out <= w_ctrl_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out.range_sum;
    assign o_status    = r_out.status;

    // sweep owns the write port while the store is being cleared
    assign w_mem_wr_en   = r_clr_busy ? 1'b1 : w_ctrl_wr_en;
    assign w_mem_wr_addr = r_clr_busy ? r_clr_idx : AW'(w_ctrl_wr_addr);
    assign w_mem_wr_data = r_clr_busy ? '0 : w_ctrl_wr_data;

    rsum_ctrl #(
        .MAX_LEAVES (MAX_LEAVES),
        .NODE_W     (NODE_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_xfer),
        .i_req     (w_req),
        .i_eff_len (r_eff_len),
        .o_idle    (w_ctrl_idle),
        .o_done    (w_ctrl_done),
        .i_take    (w_take),
        .o_result  (w_ctrl_result),
        .o_rd_en   (w_ctrl_rd_en),
        .o_rd_addr (w_ctrl_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_ctrl_wr_en),
        .o_wr_addr (w_ctrl_wr_addr),
        .o_wr_data (w_ctrl_wr_data)
    );

    rsum_mem #(
        .AW         (AW),
        .TREE_NODES (TREE_NODES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_ctrl_rd_en),
        .i_rd_addr (AW'(w_ctrl_rd_addr)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data)
    );

    a_no_walk_during_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_ctrl_wr_en && !w_ctrl_rd_en
    ) else $error("tree walk overlaps store clearing");

    a_start_leaves_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !w_ctrl_idle
    ) else $error("accepted item did not start a walk");

    a_dropped_has_zero_sum: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == rsum_pkg::STATUS_DROPPED |-> o_range_sum == '0
    ) else $error("dropped update carries a nonzero sum");

    a_done_not_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl_done |-> !r_clr_busy
    ) else $error("result produced while clearing");

endmodule
